FILE: rtl/positional_sequence_store_assert.svh
// Assertion macros for the positional sequence store checker.
// Depends on nothing; included by the checker file only.
`ifndef POSITIONAL_SEQUENCE_STORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pss checker: same-cycle rule violated");

// Next-cycle implication, disabled while reset is asserted
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pss checker: next-cycle rule violated");

`endif

FILE: rtl/pss_pkg.sv
// Shared types and constants for the positional sequence store.
// Used by the controller, the datapath, the top level and the checker.
package pss_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 6;
	localparam int ELEM_W  = 32;
	localparam int COUNT_W = 6;
	localparam int FUNC_W  = 3;

	// occupancy holds 0..CAPACITY, read index holds 0..CAPACITY-1
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	// compare width: covers position, occupancy+1 and cell index
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [FUNC_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_READOUT   = 3'd6,
		OP_COUNT     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_BUSY = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch an accepted request
		logic load;     // apply operation / emit one result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic res_last; // the result about to be loaded ends this request
	} dp_status_t;

endpackage

FILE: rtl/pss_ctrl.sv
// Controller for the positional sequence store: request/result sequencing.
// Depends on pss_pkg; drives cmd_t to pss_datapath and owns the output valid.
module pss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output pss_pkg::cmd_t         cmd,
	input  pss_pkg::dp_status_t   sts
);

	pss_pkg::state_t state_q, state_d;
	logic            m_tvalid_q;
	logic            out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			pss_pkg::S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = pss_pkg::S_BUSY;
				end
			end
			pss_pkg::S_BUSY: begin
				cmd.load = out_free;
				if (out_free && sts.res_last) begin
					state_d = pss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pss_pkg::S_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: rtl/pss_datapath.sv
// Datapath for the positional sequence store: cell row, occupancy, readout
// index and result register. Depends on pss_pkg; commanded by pss_ctrl.
module pss_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pss_pkg::cmd_t                 cmd,
	output pss_pkg::dp_status_t           sts,
	input  logic [pss_pkg::FUNC_W-1:0]    func,
	input  logic [pss_pkg::VALUE_W-1:0]   value,
	input  logic [pss_pkg::POS_W-1:0]     position,
	output logic [1:0]                    status,
	output logic [pss_pkg::ELEM_W-1:0]    element,
	output logic                          has_data,
	output logic [pss_pkg::COUNT_W-1:0]   count,
	output logic                          final_item
);

	localparam int CAP   = pss_pkg::CAPACITY;
	localparam int DW    = pss_pkg::DATA_WIDTH;
	localparam int CMP_W = pss_pkg::CMP_W;
	localparam int CNT_W = pss_pkg::CNT_W;
	localparam int IDX_W = pss_pkg::IDX_W;

	// latched request
	pss_pkg::op_t               func_q;
	logic [DW-1:0]              value_q;
	logic [pss_pkg::POS_W-1:0]  pos_q;

	logic [CNT_W-1:0]  occ_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [DW-1:0]     cells_q [CAP];
	logic [DW-1:0]     cells_d [CAP];

	// result register
	pss_pkg::status_t            status_q;
	logic [pss_pkg::ELEM_W-1:0]  element_q;
	logic                        has_data_q;
	logic [pss_pkg::COUNT_W-1:0] count_q;
	logic                        last_q;

	pss_pkg::status_t  st_c;
	logic              do_ins, do_del;
	logic [CMP_W-1:0]  tgt_c, idx_c, pos_ext, occ_ext;
	logic [CNT_W-1:0]  occ_nxt;
	logic              full, empty, is_rd;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= pss_pkg::op_t'(func);
			value_q <= DW'(value);
			pos_q   <= position;
		end
	end

	assign pos_ext = CMP_W'(pos_q);
	assign occ_ext = CMP_W'(occ_q);
	assign full    = (occ_q == CNT_W'(CAP));
	assign empty   = (occ_q == '0);
	assign is_rd   = (func_q == pss_pkg::OP_READOUT);

	// operation decode: status, target position (1-based) and shift direction
	always_comb begin
		st_c   = pss_pkg::ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		tgt_c  = '0;
		case (func_q) inside
			pss_pkg::OP_INS_FRONT, pss_pkg::OP_INS_BACK, pss_pkg::OP_INS_POS: begin
				if (full) begin
					st_c = pss_pkg::ST_FULL;
				end else if (func_q == pss_pkg::OP_INS_FRONT) begin
					tgt_c  = CMP_W'(1);
					do_ins = 1'b1;
				end else if (func_q == pss_pkg::OP_INS_BACK) begin
					tgt_c  = occ_ext + CMP_W'(1);
					do_ins = 1'b1;
				end else if (pos_ext == '0 || pos_ext > occ_ext + CMP_W'(1)) begin
					st_c = pss_pkg::ST_RANGE;
				end else begin
					tgt_c  = pos_ext;
					do_ins = 1'b1;
				end
			end
			pss_pkg::OP_DEL_FRONT, pss_pkg::OP_DEL_BACK, pss_pkg::OP_DEL_POS: begin
				if (empty) begin
					st_c = pss_pkg::ST_EMPTY;
				end else if (func_q == pss_pkg::OP_DEL_FRONT) begin
					tgt_c  = CMP_W'(1);
					do_del = 1'b1;
				end else if (func_q == pss_pkg::OP_DEL_BACK) begin
					tgt_c  = occ_ext;
					do_del = 1'b1;
				end else if (pos_ext == '0 || pos_ext > occ_ext) begin
					st_c = pss_pkg::ST_RANGE;
				end else begin
					tgt_c  = pos_ext;
					do_del = 1'b1;
				end
			end
			default: begin
				st_c = pss_pkg::ST_OK;
			end
		endcase
	end

	assign idx_c = tgt_c - CMP_W'(1);

	always_comb begin
		occ_nxt = occ_q;
		if (do_ins) begin
			occ_nxt = occ_q + CNT_W'(1);
		end else if (do_del) begin
			occ_nxt = occ_q - CNT_W'(1);
		end
	end

	// per-cell next value: write, take left neighbor (insert) or right (delete)
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic [DW-1:0] left_v, right_v;
		if (g == 0) begin : g_first
			assign left_v = cells_q[g];
		end else begin : g_left
			assign left_v = cells_q[g-1];
		end
		if (g == CAP - 1) begin : g_lastc
			assign right_v = cells_q[g];
		end else begin : g_right
			assign right_v = cells_q[g+1];
		end

		always_comb begin
			cells_d[g] = cells_q[g];
			if (do_ins) begin
				if (CMP_W'(g) == idx_c) begin
					cells_d[g] = value_q;
				end else if (CMP_W'(g) > idx_c) begin
					cells_d[g] = left_v;
				end
			end else if (do_del) begin
				if (CMP_W'(g) >= idx_c) begin
					cells_d[g] = right_v;
				end
			end
		end
	end

	// cell row
	always_ff @(posedge clk) begin
		if (cmd.load && !is_rd) begin
			for (int i = 0; i < CAP; i++) begin
				cells_q[i] <= cells_d[i];
			end
		end
	end

	// occupancy and readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load && !is_rd) begin
				occ_q <= occ_nxt;
			end
			if (cmd.capture) begin
				rd_idx_q <= '0;
			end else if (cmd.load) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	// this load closes the request
	assign sts.res_last = !is_rd || empty ||
		((CNT_W'(rd_idx_q) + CNT_W'(1)) == occ_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= sts.res_last;
			if (is_rd) begin
				status_q <= pss_pkg::ST_OK;
				count_q  <= pss_pkg::COUNT_W'(occ_q);
				if (empty) begin
					element_q  <= '0;
					has_data_q <= 1'b0;
				end else begin
					element_q  <= pss_pkg::ELEM_W'(cells_q[rd_idx_q]);
					has_data_q <= 1'b1;
				end
			end else begin
				status_q   <= st_c;
				count_q    <= pss_pkg::COUNT_W'(occ_nxt);
				element_q  <= '0;
				has_data_q <= 1'b0;
			end
		end
	end

	assign status     = status_q;
	assign element    = element_q;
	assign has_data   = has_data_q;
	assign count      = count_q;
	assign final_item = last_q;

endmodule

FILE: rtl/positional_sequence_store.sv
// An accepted request is captured, and its result is loaded into the output
// register once that register is free. Readout gives one element per cycle,
// unless the output is held, from the single read port of the cell row.
// A held output result stalls the next load, not the next request accept.
// Reset (arst_n low) empties the list; cell contents are not cleared.
module positional_sequence_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pss_pkg::S_TDATA_W-1:0]    s_tdata,  // value[31:0], position[37:32], zero pad
	input  logic [pss_pkg::FUNC_W-1:0]       s_tuser,  // func[2:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pss_pkg::M_TDATA_W-1:0]    m_tdata,  // status[1:0], element[33:2], count[39:34]
	output logic [0:0]                       m_tuser,  // has_data[0]
	output logic                             m_tlast   // final_item
);

	pss_pkg::cmd_t       cmd;
	pss_pkg::dp_status_t sts;

	logic [1:0]                      status;
	logic [pss_pkg::ELEM_W-1:0]      element;
	logic                            has_data;
	logic [pss_pkg::COUNT_W-1:0]     count;
	logic                            final_item;

	pss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pss_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (s_tuser),
		.value      (s_tdata[pss_pkg::VALUE_W-1:0]),
		.position   (s_tdata[pss_pkg::VALUE_W +: pss_pkg::POS_W]),
		.status     (status),
		.element    (element),
		.has_data   (has_data),
		.count      (count),
		.final_item (final_item)
	);

	// result packing, low field first
	assign m_tdata = {count, element, status};
	assign m_tuser = has_data;
	assign m_tlast = final_item;

endmodule

FILE: rtl/pss_checker.sv
// Port-level checker for the positional sequence store, bound to the top.
// Depends on pss_pkg and positional_sequence_store_assert.svh.
`include "positional_sequence_store_assert.svh"

module pss_port_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [pss_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [0:0]                    m_tuser,
	input  logic                          m_tlast
);

	// a stalled result holds its payload
	`PSS_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// one request at a time: no accept right after an accept
	`PSS_ASSERT_NXT(a_one_req, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// reported count never exceeds capacity
	`PSS_ASSERT_IMP(a_count, clk, arst_n, m_tvalid, {1'b0, m_tdata[39:34]} <= 7'(pss_pkg::CAPACITY))

	// a data-bearing result is a readout element with ok status
	`PSS_ASSERT_IMP(a_data_ok, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[1:0] == pss_pkg::ST_OK)

	// results without data carry a zero element
	`PSS_ASSERT_IMP(a_no_data, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[33:2] == '0)

endmodule

bind positional_sequence_store pss_port_checker u_pss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
